/* rtl/nmea_position_extractor_top_assert.svh */
// Assertion macros for the NMEA position extractor.
// Used by nmea_position_extractor_top; no other dependencies.
`ifndef NMEA_POSITION_EXTRACTOR_TOP_ASSERT_SVH
`define NMEA_POSITION_EXTRACTOR_TOP_ASSERT_SVH

`ifndef SYNTHESIS

// checked only while out of reset
`define NPE_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// checked on every edge, reset included
`define NPE_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`else

`define NPE_ASSERT(lbl, prop, msg)
`define NPE_ASSERT_ALWAYS(lbl, prop, msg)

`endif

`endif

/* rtl/npe_pkg.sv */
// Shared types and constants for the NMEA position extractor.
// No dependencies.
package npe_pkg;

    typedef enum logic [1:0] {
        PH_IDLE,
        PH_HEADER,
        PH_FIELDS
    } phase_t;

    typedef enum logic [1:0] {
        NP_INT,
        NP_FRAC,
        NP_STOP
    } num_phase_t;

    // per-stage load enables of the conversion pipeline
    typedef struct packed {
        logic ld1;
        logic ld2;
        logic ld3;
    } pipe_ctrl_t;

    localparam logic [7:0] CH_DOLLAR = 8'h24;
    localparam logic [7:0] CH_NL     = 8'h0A;
    localparam logic [7:0] CH_COMMA  = 8'h2C;
    localparam logic [7:0] CH_DOT    = 8'h2E;
    localparam logic [7:0] CH_ZERO   = 8'h30;
    localparam logic [7:0] CH_NINE   = 8'h39;
    localparam logic [7:0] CH_S      = 8'h53;
    localparam logic [7:0] CH_W      = 8'h57;

    localparam logic [0:4][7:0] HDR_GGA = {8'h47, 8'h50, 8'h47, 8'h47, 8'h41};
    localparam logic [0:4][7:0] HDR_RMC = {8'h47, 8'h50, 8'h52, 8'h4D, 8'h43};
    localparam logic [2:0] HDR_LAST = 3'd4;

    // header candidate bits: bit 0 GGA, bit 1 RMC
    localparam logic [1:0] CAND_BOTH = 2'b11;
    localparam logic [1:0] CAND_NONE = 2'b00;

    localparam logic KIND_GGA = 1'b0;
    localparam logic KIND_RMC = 1'b1;

    localparam logic [3:0] FIELD_MAX = 4'd15;
    localparam logic [3:0] FIELD_LAT = 4'd2;
    localparam logic [9:0] DEG_MAX   = 10'd999;
    localparam logic [1:0] DIR_ONE   = 2'd1;
    localparam logic [1:0] DIR_MANY  = 2'd2;

    localparam logic [23:0] TEN_POW7 = 24'd10000000;
    // ceil(2^32 / 15); exact floor(x / 15) for x below 3.0e8
    localparam logic [31:0] RECIP_15 = 32'd286331154;

    // weight of the fraction value when cnt digits were taken: 10^(7-cnt)
    function automatic logic [23:0] frac_scale(input logic [2:0] cnt);
        logic [23:0] s;
        case (cnt)
            3'd0:    s = 24'd10000000;
            3'd1:    s = 24'd1000000;
            3'd2:    s = 24'd100000;
            3'd3:    s = 24'd10000;
            3'd4:    s = 24'd1000;
            3'd5:    s = 24'd100;
            3'd6:    s = 24'd10;
            default: s = 24'd1;
        endcase
        return s;
    endfunction

endpackage

/* rtl/npe_parser.sv */
// Character-level sentence parser: header match, field count, coordinate text.
// Depends on npe_pkg.
module npe_parser #(
    parameter int FRACTION_DIGITS = 5,
    parameter int FW = 17,
    parameter int CW = 3
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   byte_fire,
    input  logic [7:0]             rx_byte,
    output logic                   emit,
    output logic                   kind,
    output logic [1:0][9:0]        deg,
    output logic [1:0][3:0]        min_tens,
    output logic [1:0][3:0]        min_ones,
    output logic [1:0][FW-1:0]     frac,
    output logic [1:0][CW-1:0]     frac_cnt,
    output logic [1:0]             negative
);
    import npe_pkg::*;

    phase_t                phase_reg, phase_next;
    logic [2:0]            pos_reg, pos_next;
    logic [1:0]            cand_reg, cand_next;
    logic [3:0]            fn_reg, fn_next;
    logic [1:0][9:0]       deg_reg, deg_next;
    logic [1:0][3:0]       tens_reg, tens_next;
    logic [1:0][3:0]       ones_reg, ones_next;
    logic [1:0][FW-1:0]    frac_reg, frac_next;
    logic [1:0][CW-1:0]    cnt_reg, cnt_next;
    num_phase_t [1:0]      np_reg, np_next;
    logic [1:0]            pres_reg, pres_next;
    logic [1:0]            neg_reg, neg_next;
    logic [1:0][1:0]       dlen_reg, dlen_next;

    logic [1:0]  cand_hdr;
    logic        is_digit;
    logic [3:0]  digit;
    logic [3:0]  base;
    logic [1:0][3:0] nf;
    logic [1:0][3:0] df;
    logic [1:0]  pres_eff;
    logic [13:0] deg_wide;

    assign cand_hdr = cand_reg & {rx_byte == HDR_RMC[pos_reg], rx_byte == HDR_GGA[pos_reg]};
    assign is_digit = (rx_byte >= CH_ZERO) && (rx_byte <= CH_NINE);
    assign digit    = rx_byte[3:0];
    assign kind     = cand_reg[0] ? KIND_GGA : KIND_RMC;
    assign base     = FIELD_LAT + {3'd0, kind};

    always_comb
    begin
        for (int c = 0; c < 2; c++)
        begin
            nf[c] = base + 4'(2 * c);
            df[c] = nf[c] + 4'd1;
            // a field still open at newline counts as empty
            pres_eff[c] = pres_reg[c] && (fn_reg != nf[c]);
            negative[c] = neg_reg[c] && (fn_reg != df[c]);
        end
    end

    assign emit     = (rx_byte == CH_NL) && (phase_reg == PH_FIELDS) && (&pres_eff);
    assign deg      = deg_reg;
    assign min_tens = tens_reg;
    assign min_ones = ones_reg;
    assign frac     = frac_reg;
    assign frac_cnt = cnt_reg;

    // next state
    always_comb
    begin
        phase_next = phase_reg;
        if (rx_byte == CH_DOLLAR)
        begin
            phase_next = PH_HEADER;
        end
        else if (rx_byte == CH_NL)
        begin
            phase_next = PH_IDLE;
        end
        else
        begin
            unique case (phase_reg)
                PH_HEADER:
                begin
                    if (cand_hdr == CAND_NONE)
                        phase_next = PH_IDLE;
                    else if (pos_reg == HDR_LAST)
                        phase_next = PH_FIELDS;
                end
                PH_IDLE, PH_FIELDS: phase_next = phase_reg;
                default:            phase_next = PH_IDLE;
            endcase
        end
    end

    // datapath
    always_comb
    begin
        pos_next  = pos_reg;
        cand_next = cand_reg;
        fn_next   = fn_reg;
        deg_next  = deg_reg;
        tens_next = tens_reg;
        ones_next = ones_reg;
        frac_next = frac_reg;
        cnt_next  = cnt_reg;
        np_next   = np_reg;
        pres_next = pres_reg;
        neg_next  = neg_reg;
        dlen_next = dlen_reg;
        deg_wide  = '0;

        if (rx_byte == CH_DOLLAR || rx_byte == CH_NL)
        begin
            pos_next  = '0;
            cand_next = CAND_BOTH;
            fn_next   = '0;
            if (rx_byte == CH_DOLLAR)
            begin
                deg_next  = '0;
                tens_next = '0;
                ones_next = '0;
                frac_next = '0;
                cnt_next  = '0;
                np_next   = '{NP_INT, NP_INT};
                pres_next = '0;
                neg_next  = '0;
                dlen_next = '0;
            end
        end
        else
        begin
            unique case (phase_reg)
                PH_HEADER:
                begin
                    if (cand_hdr == CAND_NONE)
                    begin
                        pos_next  = '0;
                        cand_next = CAND_BOTH;
                    end
                    else if (pos_reg == HDR_LAST)
                    begin
                        cand_next = cand_hdr;
                        fn_next   = '0;
                        deg_next  = '0;
                        tens_next = '0;
                        ones_next = '0;
                        frac_next = '0;
                        cnt_next  = '0;
                        np_next   = '{NP_INT, NP_INT};
                        pres_next = '0;
                        neg_next  = '0;
                        dlen_next = '0;
                    end
                    else
                    begin
                        cand_next = cand_hdr;
                        pos_next  = pos_reg + 3'd1;
                    end
                end
                PH_FIELDS:
                begin
                    for (int c = 0; c < 2; c++)
                    begin
                        if (rx_byte == CH_COMMA)
                        begin
                            if (fn_reg == df[c] && dlen_reg[c] != DIR_ONE)
                                neg_next[c] = 1'b0;
                        end
                        else if (fn_reg == nf[c])
                        begin
                            pres_next[c] = 1'b1;
                            case (np_reg[c])
                                NP_INT:
                                begin
                                    if (is_digit)
                                    begin
                                        // shift one decimal digit through ddd|m|m
                                        deg_wide = 14'(deg_reg[c]) * 14'd10 + 14'(tens_reg[c]);
                                        if (deg_wide > 14'(DEG_MAX))
                                        begin
                                            deg_next[c]  = DEG_MAX;
                                            tens_next[c] = 4'd9;
                                            ones_next[c] = 4'd9;
                                        end
                                        else
                                        begin
                                            deg_next[c]  = deg_wide[9:0];
                                            tens_next[c] = ones_reg[c];
                                            ones_next[c] = digit;
                                        end
                                    end
                                    else if (rx_byte == CH_DOT)
                                        np_next[c] = NP_FRAC;
                                    else
                                        np_next[c] = NP_STOP;
                                end
                                NP_FRAC:
                                begin
                                    if (is_digit)
                                    begin
                                        if (cnt_reg[c] < CW'(FRACTION_DIGITS))
                                        begin
                                            frac_next[c] = frac_reg[c] * FW'(10) + FW'(digit);
                                            cnt_next[c]  = cnt_reg[c] + CW'(1);
                                        end
                                    end
                                    else
                                        np_next[c] = NP_STOP;
                                end
                                default: ;
                            endcase
                        end
                        else if (fn_reg == df[c])
                        begin
                            if (dlen_reg[c] == 2'd0 && (rx_byte == CH_S || rx_byte == CH_W))
                                neg_next[c] = 1'b1;
                            if (dlen_reg[c] < DIR_MANY)
                                dlen_next[c] = dlen_reg[c] + 2'd1;
                        end
                    end
                    if (rx_byte == CH_COMMA && fn_reg < FIELD_MAX)
                        fn_next = fn_reg + 4'd1;
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_IDLE;
            pos_reg   <= '0;
            cand_reg  <= CAND_BOTH;
            fn_reg    <= '0;
            deg_reg   <= '0;
            tens_reg  <= '0;
            ones_reg  <= '0;
            frac_reg  <= '0;
            cnt_reg   <= '0;
            np_reg    <= '{NP_INT, NP_INT};
            pres_reg  <= '0;
            neg_reg   <= '0;
            dlen_reg  <= '0;
        end
        else if (byte_fire)
        begin
            phase_reg <= phase_next;
            pos_reg   <= pos_next;
            cand_reg  <= cand_next;
            fn_reg    <= fn_next;
            deg_reg   <= deg_next;
            tens_reg  <= tens_next;
            ones_reg  <= ones_next;
            frac_reg  <= frac_next;
            cnt_reg   <= cnt_next;
            np_reg    <= np_next;
            pres_reg  <= pres_next;
            neg_reg   <= neg_next;
            dlen_reg  <= dlen_next;
        end
    end

endmodule

/* rtl/npe_coord_conv.sv */
// Three-stage conversion of one coordinate to signed 1e-7 degree units.
// Depends on npe_pkg.
module npe_coord_conv #(
    parameter int FW = 17,
    parameter int CW = 3
) (
    input  logic                    clk,
    input  npe_pkg::pipe_ctrl_t     ctrl,
    input  logic [9:0]              deg,
    input  logic [3:0]              min_tens,
    input  logic [3:0]              min_ones,
    input  logic [FW-1:0]           frac,
    input  logic [CW-1:0]           frac_cnt,
    input  logic                    negative,
    output logic signed [34:0]      value
);
    import npe_pkg::*;

    logic [6:0]  minutes;
    logic [29:0] n_next, n_reg;
    logic [9:0]  deg1_reg, deg2_reg;
    logic        neg1_reg, neg2_reg;
    logic [59:0] prod;
    logic [23:0] q_next, q_reg;
    logic [34:0] v;
    logic [34:0] value_next, value_reg;

    // stage 1: minutes scaled by 1e7 (fraction aligned to 1e-7 minute)
    assign minutes = 7'(min_tens) * 7'd10 + 7'(min_ones);
    assign n_next  = 30'(minutes) * 30'(TEN_POW7)
                   + 30'(frac) * 30'(frac_scale(3'(frac_cnt)));

    // stage 2: divide by 60 as shift by 2 then reciprocal of 15
    assign prod   = {32'd0, n_reg[29:2]} * {28'd0, RECIP_15};
    assign q_next = prod[55:32];

    // stage 3: add whole degrees and apply the sign
    assign v          = 35'(deg2_reg) * 35'(TEN_POW7) + 35'(q_reg);
    assign value_next = neg2_reg ? (35'd0 - v) : v;

    always_ff @(posedge clk)
    begin
        if (ctrl.ld1)
        begin
            n_reg    <= n_next;
            deg1_reg <= deg;
            neg1_reg <= negative;
        end
        if (ctrl.ld2)
        begin
            q_reg    <= q_next;
            deg2_reg <= deg1_reg;
            neg2_reg <= neg1_reg;
        end
        if (ctrl.ld3)
            value_reg <= value_next;
    end

    assign value = value_reg;

endmodule

/* rtl/nmea_position_extractor_top.sv */
// NMEA 0183 position extractor: top level with pipeline control.
// Depends on npe_pkg, npe_parser, npe_coord_conv and the assertion macro header.
//
// Input channel in_valid/in_ready carries one received character (rx_byte) per
// transfer. $GPGGA and $GPRMC sentences are followed; at newline, when both the
// latitude and longitude fields were given, one result goes out on out_valid/
// out_ready: latitude and longitude in signed 1e-7 degree units and
// sentence_kind (0 GGA, 1 RMC). Other characters give no result.
// Throughput: one character per cycle while in_ready is high. After the newline
// transfer, a result passes through the three conversion registers (scaling
// multiply, reciprocal divide by 60, degree add and sign) before out_valid rises.
// Reset clears the parser to idle and empties the pipeline; no clearing pass.
// When out_ready stays low, the result holds on the output register and
// bubbles ahead of it fill; in_ready drops only when all three stages are full.
`include "nmea_position_extractor_top_assert.svh"

module nmea_position_extractor_top #(
    parameter int FRACTION_DIGITS = 5
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic [7:0]         rx_byte,
    output logic               out_valid,
    input  logic               out_ready,
    output logic signed [34:0] latitude,
    output logic signed [34:0] longitude,
    output logic               sentence_kind
);
    import npe_pkg::*;

    localparam int FW = $clog2(10 ** FRACTION_DIGITS);
    localparam int CW = $clog2(FRACTION_DIGITS + 1);

    logic               in_fire;
    logic               emit_now;
    logic               kind;
    logic [1:0][9:0]    deg;
    logic [1:0][3:0]    min_tens;
    logic [1:0][3:0]    min_ones;
    logic [1:0][FW-1:0] frac;
    logic [1:0][CW-1:0] frac_cnt;
    logic [1:0]         negative;

    logic v1_reg, v2_reg, v3_reg;
    logic k1_reg, k2_reg, k3_reg;
    logic en1, en2, en3;
    pipe_ctrl_t ctrl;

    assign en3      = !v3_reg || out_ready;
    assign en2      = !v2_reg || en3;
    assign en1      = !v1_reg || en2;
    assign in_ready = en1;
    assign in_fire  = in_valid && in_ready;
    assign ctrl     = '{ld1: en1, ld2: en2, ld3: en3};

    npe_parser #(
        .FRACTION_DIGITS(FRACTION_DIGITS),
        .FW(FW),
        .CW(CW)
    ) u_parser (
        .clk(clk),
        .rst_n(rst_n),
        .byte_fire(in_fire),
        .rx_byte(rx_byte),
        .emit(emit_now),
        .kind(kind),
        .deg(deg),
        .min_tens(min_tens),
        .min_ones(min_ones),
        .frac(frac),
        .frac_cnt(frac_cnt),
        .negative(negative)
    );

    npe_coord_conv #(
        .FW(FW),
        .CW(CW)
    ) u_conv_lat (
        .clk(clk),
        .ctrl(ctrl),
        .deg(deg[0]),
        .min_tens(min_tens[0]),
        .min_ones(min_ones[0]),
        .frac(frac[0]),
        .frac_cnt(frac_cnt[0]),
        .negative(negative[0]),
        .value(latitude)
    );

    npe_coord_conv #(
        .FW(FW),
        .CW(CW)
    ) u_conv_lon (
        .clk(clk),
        .ctrl(ctrl),
        .deg(deg[1]),
        .min_tens(min_tens[1]),
        .min_ones(min_ones[1]),
        .frac(frac[1]),
        .frac_cnt(frac_cnt[1]),
        .negative(negative[1]),
        .value(longitude)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end
        else
        begin
            if (en1)
                v1_reg <= in_fire && emit_now;
            if (en2)
                v2_reg <= v1_reg;
            if (en3)
                v3_reg <= v2_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en1)
            k1_reg <= kind;
        if (en2)
            k2_reg <= k1_reg;
        if (en3)
            k3_reg <= k2_reg;
    end

    assign out_valid     = v3_reg;
    assign sentence_kind = k3_reg;

    `NPE_ASSERT(a_no_spurious_result, in_fire && !emit_now |=> !v1_reg, "result from a non-emitting byte")
    `NPE_ASSERT(a_result_enters, in_fire && emit_now |=> v1_reg, "completed sentence lost")
    `NPE_ASSERT(a_out_from_stage2, $rose(out_valid) |-> $past(v2_reg), "result skipped a stage")
    `NPE_ASSERT_ALWAYS(a_ready_when_empty_out, !out_valid |-> in_ready, "input stalled with free output")

endmodule
